FILE: rtl/sbcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcg_pkg
// Shared constants and types of the sprite blit command generator.
// ----------------------------------------------------------------------------
package sbcg_pkg;

	localparam int BUF_WIDTH        = 512;
	localparam int BUF_HEIGHT       = 256;
	localparam int FIRST_LINE       = 200;
	localparam int MAX_FRAME_HEIGHT = 40;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_DATA_W = 8;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_PREP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic prep;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic fits;
		logic last_row;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/sbcg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcg_ctrl
// Sequencer: take a descriptor, evaluate it, drop it if rejected, else adjust the source if clipped and emit rows.
// ----------------------------------------------------------------------------
module sbcg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  sbcg_pkg::status_t status,
	output sbcg_pkg::cmd_t    cmd
);
	import sbcg_pkg::*;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				priority if (status.reject) state_d = ST_IDLE;
				else if (status.fits) state_d = ST_EMIT;
				else state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last_row) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/sbcg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcg_dp
// Datapath: descriptor registers, clipping, row address math, output word.
// ----------------------------------------------------------------------------
module sbcg_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [sbcg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [sbcg_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sbcg_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast,
	output logic                               m_tuser,
	input  sbcg_pkg::cmd_t                     cmd,
	output sbcg_pkg::status_t                  status
);
	import sbcg_pkg::*;

	logic [7:0] base_page_q;

	// latched descriptor
	logic [7:0]         sp_q;
	logic [13:0]        so_q;
	logic [7:0]         flen_q;
	logic [5:0]         h_q;
	logic [7:0]         dx_q;
	logic [7:0]         dy_q;
	logic [7:0]         w_q;
	logic signed [10:0] px_q;
	logic signed [9:0]  py_q;

	// evaluated frame
	logic [8:0]  bx_q;
	logic [8:0]  line_q;
	logic [5:0]  rows_q;
	logic [7:0]  w1_q;
	logic [7:0]  w2_q;
	logic [13:0] prod_q;
	logic        inside_q;

	// output word
	logic        out_valid_q;
	logic [13:0] o_so_q, o_dofs_q, o_so2_q, o_dofs2_q;
	logic [7:0]  o_sp_q, o_dp_q, o_len_q, o_sp2_q, o_len2_q;
	logic [5:0]  o_rows_q;
	logic        o_has2_q, o_last_q;

	// evaluation logic
	logic [8:0]         bx;
	logic signed [10:0] by;
	logic [5:0]         hc;
	logic               neg_top;
	logic [5:0]         topcut;
	logic signed [9:0]  h_a;
	logic signed [9:0]  h_b;
	logic [8:0]         by0;
	logic [9:0]         rem;
	logic [7:0]         w1c, w1, w2d, w2;
	logic               fits;
	logic               reject;

	always_comb begin
		bx      = px_q[8:0] + {1'b0, dx_q};
		by      = 11'(py_q) + $signed({3'b000, dy_q});
		hc      = (h_q > 6'(MAX_FRAME_HEIGHT)) ? 6'(MAX_FRAME_HEIGHT) : h_q;
		neg_top = by < 0;
		topcut  = 6'(-by);
		h_a     = neg_top ? ($signed({4'b0000, hc}) + 10'(by)) : $signed({4'b0000, hc});
		by0     = neg_top ? 9'd0 : by[8:0];
		// clip the bottom edge
		if ($signed({1'b0, by0}) + h_a > 10'sd256) h_b = 10'sd256 - $signed({1'b0, by0});
		else h_b = h_a;
		rem     = 10'(BUF_WIDTH) - {1'b0, bx};
		w1c     = ({2'b00, w_q} <= rem) ? w_q : rem[7:0];
		w1      = {w1c[7:1], 1'b0};
		w2d     = w_q - w1;
		w2      = {w2d[7:1], 1'b0};
		fits    = !neg_top && ({2'b00, by[8:0]} + {4'b0000, hc} <= 11'(BUF_HEIGHT))
			&& ({1'b0, bx} + {2'b00, w_q} <= 10'(BUF_WIDTH)) && (by < 11'sd256);
		reject  = (w_q == 8'd0) || (h_q == 6'd0) || bx[0]
			|| (by <= -11'sd40) || (by >= 11'sd256)
			|| (!fits && ((h_b <= 10'sd0) || ((w1 == 8'd0) && (w2 == 8'd0))));
	end

	// row generation
	logic [13:0] ro;
	logic [7:0]  rp;
	logic [14:0] so2_sum, adv_sum, prep_sum;
	logic [7:0]  len1, len2;

	always_comb begin
		ro       = {line_q[4:0], 9'd0};
		rp       = base_page_q + {4'd0, line_q[8:5]};
		so2_sum  = {1'b0, so_q} + {7'd0, w1_q};
		adv_sum  = {1'b0, so_q} + {7'd0, w_q};
		prep_sum = {1'b0, so_q} + {1'b0, prod_q};
		len1     = {1'b0, w1_q[7:1]} - 8'd1;
		len2     = {1'b0, w2_q[7:1]} - 8'd1;
	end

	assign status.reject   = reject;
	assign status.fits     = fits;
	assign status.last_row = inside_q || (rows_q == 6'd1);
	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) base_page_q <= cfg_data;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sp_q   <= s_tdata[7:0];
			so_q   <= s_tdata[21:8];
			flen_q <= s_tdata[29:22];
			h_q    <= s_tdata[35:30];
			dx_q   <= s_tdata[43:36];
			dy_q   <= s_tdata[51:44];
			w_q    <= s_tdata[59:52];
			px_q   <= s_tdata[70:60];
			py_q   <= s_tdata[80:71];
		end
		if (cmd.eval) begin
			bx_q     <= bx;
			inside_q <= fits;
			line_q   <= (fits ? by[8:0] : by0) + 9'(FIRST_LINE);
			rows_q   <= fits ? hc : h_b[5:0];
			w1_q     <= w1;
			w2_q     <= w2;
			prod_q   <= neg_top ? ({8'd0, topcut} * {6'd0, w_q}) : 14'd0;
		end
		if (cmd.prep) begin
			so_q <= prep_sum[13:0];
			sp_q <= sp_q + {7'd0, prep_sum[14]};
		end
		if (cmd.emit) begin
			o_so_q   <= so_q;
			o_sp_q   <= sp_q;
			o_dp_q   <= rp;
			o_so2_q  <= '0;
			o_sp2_q  <= '0;
			o_dofs2_q <= '0;
			o_len2_q <= '0;
			o_has2_q <= 1'b0;
			if (inside_q) begin
				o_dofs_q <= ro + {5'd0, bx_q};
				o_len_q  <= flen_q;
				o_rows_q <= rows_q - 6'd1;
				o_last_q <= 1'b1;
			end else begin
				o_rows_q <= '0;
				o_last_q <= (rows_q == 6'd1);
				if (w1_q == 8'd0) begin
					// left piece empty: wrapped piece moves to the front
					o_dofs_q <= ro;
					o_len_q  <= len2;
				end else begin
					o_dofs_q <= ro + {5'd0, bx_q};
					o_len_q  <= len1;
					if (w2_q != 8'd0) begin
						o_has2_q  <= 1'b1;
						o_so2_q   <= so2_sum[13:0];
						o_sp2_q   <= sp_q + {7'd0, so2_sum[14]};
						o_dofs2_q <= ro;
						o_len2_q  <= len2;
					end
				end
				so_q   <= adv_sum[13:0];
				sp_q   <= sp_q + {7'd0, adv_sum[14]};
				rows_q <= rows_q - 6'd1;
				line_q <= line_q + 9'd1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_has2_q;
	assign m_tdata  = {2'b00, o_len2_q, o_dofs2_q, o_sp2_q, o_so2_q, o_rows_q,
		o_len_q, o_dp_q, o_dofs_q, o_sp_q, o_so_q};

endmodule

FILE: rtl/sprite_blit_command_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_command_generator_unit
// Turns a sprite frame descriptor and position into ring canvas copy commands.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_*     | in        | frame descriptor and position word
//  m_*     | out       | copy command word, tlast on final word of a frame
//  cfg_*   | in        | base page register write
//
//  accept and evaluate are separate states; a frame fully inside then gives
//  its one word, a clipped one passes a prep state that adjusts the source and
//  then gives one word per row, at most 40. rejected descriptors free the
//  input after evaluate; reset clears the sequencer, the output valid and
//  base_page. a stalled output holds its word and the next descriptor is
//  taken while the previous last word still waits.
module sprite_blit_command_generator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// frame_page, frame_offset, frame_len, frame_height, corner_dx, corner_dy,
	// frame_width, pos_x, pos_y, zero fill
	input  logic [sbcg_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// src_ofs, src_page, dst_ofs, dst_page, piece_len, row_count,
	// second_src_ofs, second_src_page, second_dst_ofs, second_len, zero fill
	output logic [sbcg_pkg::OUT_DATA_W-1:0]  m_tdata,
	// has_second
	output logic                             m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sbcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbcg_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	sbcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sbcg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: rtl/sbcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcg_checker
// Port level checks of the sprite blit command generator.
// ----------------------------------------------------------------------------
module sbcg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sbcg_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);
	import sbcg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// wrapped commands are always single row
	a_wrap_rows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[57:52] == 6'd0)
		else $error("wrapped command with row count");

	// a multi-row command is the only word of its frame
	a_multi_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57:52] != 6'd0 |-> m_tlast && !m_tuser)
		else $error("multi-row command not final");

	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[101:58] == 44'd0)
		else $error("second piece fields set without second piece");

endmodule

bind sprite_blit_command_generator_unit sbcg_checker u_sbcg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
